// ===== hdl/lrt_pkg.sv =====
package lrt_pkg;

    localparam int PORT_ENTRIES  = 1024;
    localparam int SOCK_ENTRIES  = 1024;
    localparam int PIDX_W        = $clog2(PORT_ENTRIES);
    localparam int SIDX_W        = $clog2(SOCK_ENTRIES);
    localparam int SWEEP_ENTRIES = (PORT_ENTRIES > SOCK_ENTRIES) ? PORT_ENTRIES : SOCK_ENTRIES;
    localparam int CNT_W         = $clog2(SWEEP_ENTRIES) + 1;

    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_FOREIGN   = 3'd1;
    localparam logic [2:0] ST_BAD       = 3'd2;
    localparam logic [2:0] ST_GATEWAY   = 3'd3;
    localparam logic [2:0] ST_UNTRACKED = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
    localparam logic [2:0] ST_SILENT    = 3'd6;

    localparam logic CMD_ADD     = 1'b0;
    localparam logic CMD_REMOVE  = 1'b1;
    localparam logic KIND_APPEAR = 1'b0;
    localparam logic KIND_VANISH = 1'b1;

    localparam logic [15:0] FAM_IPV4 = 16'd2;
    localparam logic [15:0] FAM_IPV6 = 16'd10;

    typedef struct packed {
        logic        command;
        logic [63:0] socket_id;
        logic [7:0]  protocol;
        logic [15:0] address_family;
        logic [15:0] local_port;
        logic [31:0] ipv4_address;
        logic [63:0] ipv6_address_high;
        logic [63:0] ipv6_address_low;
        logic [31:0] socket_namespace;
        logic        hook_succeeded;
    } lrt_in_t;

    typedef struct packed {
        logic        event_valid;
        logic        event_kind;
        logic [7:0]  event_protocol;
        logic [15:0] event_port;
        logic [63:0] event_address_high;
        logic [63:0] event_address_low;
        logic [2:0]  status;
    } lrt_out_t;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic [23:0] pp;
    } lrt_key_t;

    typedef struct packed {
        logic              valid;
        logic [63:0]       tag;
        lrt_key_t          key;
        logic [SIDX_W-1:0] age;
    } sock_entry_t;

    typedef struct packed {
        logic        valid;
        lrt_key_t    key;
        logic [31:0] count;
    } port_entry_t;

    function automatic logic key_ok(lrt_in_t d);
        return (d.local_port != 16'd0) &&
               (d.address_family == FAM_IPV4 || d.address_family == FAM_IPV6);
    endfunction

    function automatic lrt_key_t make_key(lrt_in_t d);
        lrt_key_t k;
        k.pp = {d.protocol, d.local_port};
        if (d.address_family == FAM_IPV4)
        begin
            k.hi = 64'd0;
            k.lo = {32'h0000FFFF, d.ipv4_address};
        end
        else
        begin
            k.hi = d.ipv6_address_high;
            k.lo = d.ipv6_address_low;
        end
        return k;
    endfunction

    function automatic logic is_gateway(lrt_key_t k);
        return (k.lo[47:0] == 48'hFFFF7F000002) ||
               (k.hi[63:48] == 16'hFD77 && k.lo[7:0] == 8'h02);
    endfunction

endpackage

// ===== hdl/listener_refcount_tracker_core.sv =====
// Channel  | Direction | Handshake            | Payload
// in       | input     | in_valid / in_stall  | in_data  (lrt_in_t)
// out      | output    | out_valid / out_stall| out_data (lrt_out_t)
// cfg      | input     | cfg_valid / cfg_ready| cfg_data (host namespace id)
//
// Each item runs through memory sweeps, and no new input is taken until it is done:
// an add or a known-socket remove walks the socket memory twice (find, update) and the
// port memory once; an unknown-socket remove skips the update sweep (and the port sweep
// on a bad key); early rejects do no sweep. After reset a clearing pass zeroes valid bits
// and ages; no input transfer is taken meanwhile (cfg writes are).
// A waiting result holds out_data; the next item may run, but its result waits for the drain.
module listener_refcount_tracker_core
    import lrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  lrt_in_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output lrt_out_t    out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_SFIND, S_SDEC, S_SUPD,
        S_KEYCHK, S_PFIND, S_PDEC, S_RESP
    } state_t;

    state_t            state_reg;
    logic [31:0]       host_ns_reg;
    lrt_in_t           in_reg;
    lrt_key_t          key_reg;
    logic [2:0]        status_reg;
    logic              ev_reg;
    logic              kind_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  didx_reg;
    logic              dvld_reg;

    // socket lookup results
    logic              sfound_reg;
    logic [SIDX_W-1:0] sidx_reg;
    logic [SIDX_W-1:0] sage_reg;
    lrt_key_t          skey_reg;
    logic              sfree_reg;
    logic [SIDX_W-1:0] sfree_idx_reg;
    logic [SIDX_W-1:0] sold_idx_reg;
    logic [SIDX_W-1:0] sold_age_reg;

    // socket update plan
    logic [SIDX_W-1:0] upd_idx_reg;
    logic [SIDX_W-1:0] upd_limit_reg;
    logic              upd_fresh_reg;
    logic              upd_del_reg;

    // port lookup results
    logic              pfound_reg;
    logic [PIDX_W-1:0] pidx_reg;
    logic [31:0]       pcount_reg;
    logic              pfree_reg;
    logic [PIDX_W-1:0] pfree_idx_reg;

    logic              out_valid_reg;
    lrt_out_t          out_data_reg;

    sock_entry_t       sock_mem [SOCK_ENTRIES];
    sock_entry_t       sock_rd_reg;
    port_entry_t       port_mem [PORT_ENTRIES];
    port_entry_t       port_rd_reg;

    logic              sock_we;
    logic [SIDX_W-1:0] sock_waddr;
    sock_entry_t       sock_wdata;
    logic              port_we;
    logic [PIDX_W-1:0] port_waddr;
    port_entry_t       port_wdata;

    logic [CNT_W-1:0]  sweep_n;
    logic              issue;
    logic              sweeping;
    logic              out_load;
    logic              last_sample;
    logic [SIDX_W-1:0] s_i;
    logic [PIDX_W-1:0] p_i;
    logic              is_add;
    lrt_key_t          in_key;
    logic [31:0]       dec_count;
    lrt_out_t          result;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    assign is_add    = (in_reg.command == CMD_ADD);
    assign in_key    = make_key(in_reg);
    assign s_i       = didx_reg[SIDX_W-1:0];
    assign p_i       = didx_reg[PIDX_W-1:0];
    assign dec_count = pcount_reg - 32'd1;

    // sweep length depends on which memory is walked
    always_comb
    begin
        unique case (state_reg)
            S_PFIND: sweep_n = CNT_W'(PORT_ENTRIES);
            S_CLEAR: sweep_n = CNT_W'(SWEEP_ENTRIES);
            default: sweep_n = CNT_W'(SOCK_ENTRIES);
        endcase
    end

    assign issue       = (cnt_reg < sweep_n);
    assign sweeping    = (state_reg == S_SFIND) || (state_reg == S_SUPD) ||
                         (state_reg == S_PFIND);
    assign last_sample = dvld_reg && (didx_reg == sweep_n - CNT_W'(1));
    // load the output register when it is empty or draining this cycle
    assign out_load    = (state_reg == S_RESP) && (!out_valid_reg || !out_stall);

    // socket memory write: clear pass or age/entry update
    always_comb
    begin
        sock_we    = 1'b0;
        sock_waddr = s_i;
        sock_wdata = sock_rd_reg;
        if (state_reg == S_CLEAR)
        begin
            sock_we    = (cnt_reg < CNT_W'(SOCK_ENTRIES));
            sock_waddr = cnt_reg[SIDX_W-1:0];
            sock_wdata = '0;
        end
        else if (state_reg == S_SUPD && dvld_reg)
        begin
            sock_we = 1'b1;
            if (s_i == upd_idx_reg)
            begin
                if (upd_del_reg)
                begin
                    sock_wdata.valid = 1'b0;
                    sock_wdata.age   = '0;
                end
                else
                begin
                    sock_wdata.valid = 1'b1;
                    sock_wdata.tag   = in_reg.socket_id;
                    sock_wdata.key   = key_reg;
                    sock_wdata.age   = '0;
                end
            end
            else if (sock_rd_reg.valid)
            begin
                if (upd_del_reg)
                begin
                    if (sock_rd_reg.age > upd_limit_reg)
                        sock_wdata.age = sock_rd_reg.age - SIDX_W'(1);
                end
                else if (upd_fresh_reg || sock_rd_reg.age < upd_limit_reg)
                begin
                    sock_wdata.age = sock_rd_reg.age + SIDX_W'(1);
                end
            end
        end
    end

    // port memory write: clear pass or the final count update
    always_comb
    begin
        port_we          = 1'b0;
        port_waddr       = pidx_reg;
        port_wdata.valid = 1'b1;
        port_wdata.key   = key_reg;
        port_wdata.count = pcount_reg;
        if (state_reg == S_CLEAR)
        begin
            port_we    = (cnt_reg < CNT_W'(PORT_ENTRIES));
            port_waddr = cnt_reg[PIDX_W-1:0];
            port_wdata = '0;
        end
        else if (state_reg == S_PDEC)
        begin
            if (is_add)
            begin
                if (pfound_reg)
                begin
                    port_we          = (pcount_reg != '1);
                    port_wdata.count = pcount_reg + 32'd1;
                end
                else if (pfree_reg)
                begin
                    port_we          = 1'b1;
                    port_waddr       = pfree_idx_reg;
                    port_wdata.count = 32'd1;
                end
            end
            else if (pfound_reg)
            begin
                port_we          = 1'b1;
                port_wdata.count = dec_count;
                port_wdata.valid = (dec_count != 32'd0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sock_rd_reg <= sock_mem[cnt_reg[SIDX_W-1:0]];
        if (sock_we)
            sock_mem[sock_waddr] <= sock_wdata;
    end

    always_ff @(posedge clk)
    begin
        port_rd_reg <= port_mem[cnt_reg[PIDX_W-1:0]];
        if (port_we)
            port_mem[port_waddr] <= port_wdata;
    end

    always_comb
    begin
        result                    = '0;
        result.status             = status_reg;
        result.event_valid        = ev_reg;
        if (ev_reg)
        begin
            result.event_kind         = kind_reg;
            result.event_protocol     = key_reg.pp[23:16];
            result.event_port         = key_reg.pp[15:0];
            result.event_address_high = key_reg.hi;
            result.event_address_low  = key_reg.lo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            host_ns_reg   <= '0;
            cnt_reg       <= '0;
            dvld_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                host_ns_reg <= cfg_data;

            // load a new result, or drain the output register
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            // sweep bookkeeping: one read per cycle, data back in the next cycle
            dvld_reg <= sweeping && issue;
            didx_reg <= cnt_reg;

            unique case (state_reg)
                S_CLEAR:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(SWEEP_ENTRIES - 1))
                        state_reg <= S_IDLE;
                end

                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        in_reg    <= in_data;
                        state_reg <= S_CHECK;
                    end
                end

                S_CHECK:
                begin
                    ev_reg       <= 1'b0;
                    cnt_reg      <= '0;
                    sfound_reg   <= 1'b0;
                    sfree_reg    <= 1'b0;
                    sold_idx_reg <= '0;
                    sold_age_reg <= '0;
                    key_reg      <= in_key;
                    if (is_add && !in_reg.hook_succeeded)
                    begin
                        status_reg <= ST_BAD;
                        state_reg  <= S_RESP;
                    end
                    else if (host_ns_reg != 32'd0 && in_reg.socket_namespace != host_ns_reg)
                    begin
                        status_reg <= ST_FOREIGN;
                        state_reg  <= S_RESP;
                    end
                    else if (is_add && !key_ok(in_reg))
                    begin
                        status_reg <= ST_BAD;
                        state_reg  <= S_RESP;
                    end
                    else if (is_add && is_gateway(in_key))
                    begin
                        status_reg <= ST_GATEWAY;
                        state_reg  <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_SFIND;
                    end
                end

                S_SFIND:
                begin
                    if (issue)
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    if (dvld_reg)
                    begin
                        if (sock_rd_reg.valid && sock_rd_reg.tag == in_reg.socket_id
                            && !sfound_reg)
                        begin
                            sfound_reg <= 1'b1;
                            sidx_reg   <= s_i;
                            sage_reg   <= sock_rd_reg.age;
                            skey_reg   <= sock_rd_reg.key;
                        end
                        if (!sock_rd_reg.valid && !sfree_reg)
                        begin
                            sfree_reg     <= 1'b1;
                            sfree_idx_reg <= s_i;
                        end
                        if (sock_rd_reg.valid && sock_rd_reg.age > sold_age_reg)
                        begin
                            sold_idx_reg <= s_i;
                            sold_age_reg <= sock_rd_reg.age;
                        end
                    end
                    if (last_sample)
                        state_reg <= S_SDEC;
                end

                S_SDEC:
                begin
                    cnt_reg <= '0;
                    if (is_add)
                    begin
                        // hit: refresh in place; miss: first free slot, else evict oldest
                        upd_del_reg   <= 1'b0;
                        upd_fresh_reg <= !sfound_reg && sfree_reg;
                        upd_idx_reg   <= sfound_reg ? sidx_reg :
                                         (sfree_reg ? sfree_idx_reg : sold_idx_reg);
                        upd_limit_reg <= sfound_reg ? sage_reg : sold_age_reg;
                        state_reg     <= S_SUPD;
                    end
                    else if (sfound_reg)
                    begin
                        upd_del_reg   <= 1'b1;
                        upd_fresh_reg <= 1'b0;
                        upd_idx_reg   <= sidx_reg;
                        upd_limit_reg <= sage_reg;
                        key_reg       <= skey_reg;
                        state_reg     <= S_SUPD;
                    end
                    else if (!key_ok(in_reg))
                    begin
                        status_reg <= ST_BAD;
                        state_reg  <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_KEYCHK;
                    end
                end

                S_SUPD:
                begin
                    if (issue)
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    if (last_sample)
                    begin
                        cnt_reg    <= '0;
                        pfound_reg <= 1'b0;
                        pfree_reg  <= 1'b0;
                        state_reg  <= upd_del_reg ? S_KEYCHK : S_PFIND;
                    end
                end

                S_KEYCHK:
                begin
                    cnt_reg    <= '0;
                    pfound_reg <= 1'b0;
                    pfree_reg  <= 1'b0;
                    if (is_gateway(key_reg))
                    begin
                        status_reg <= ST_GATEWAY;
                        state_reg  <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_PFIND;
                    end
                end

                S_PFIND:
                begin
                    if (issue)
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    if (dvld_reg)
                    begin
                        if (port_rd_reg.valid && port_rd_reg.key == key_reg && !pfound_reg)
                        begin
                            pfound_reg <= 1'b1;
                            pidx_reg   <= p_i;
                            pcount_reg <= port_rd_reg.count;
                        end
                        if (!port_rd_reg.valid && !pfree_reg)
                        begin
                            pfree_reg     <= 1'b1;
                            pfree_idx_reg <= p_i;
                        end
                    end
                    if (last_sample)
                        state_reg <= S_PDEC;
                end

                S_PDEC:
                begin
                    state_reg <= S_RESP;
                    if (is_add)
                    begin
                        if (pfound_reg)
                            status_reg <= ST_SILENT;
                        else if (pfree_reg)
                        begin
                            status_reg <= ST_DONE;
                            ev_reg     <= 1'b1;
                            kind_reg   <= KIND_APPEAR;
                        end
                        else
                            status_reg <= ST_FULL;
                    end
                    else if (!pfound_reg)
                        status_reg <= ST_UNTRACKED;
                    else if (dec_count != 32'd0)
                        status_reg <= ST_SILENT;
                    else
                    begin
                        status_reg <= ST_DONE;
                        ev_reg     <= 1'b1;
                        kind_reg   <= KIND_VANISH;
                    end
                end

                S_RESP:
                begin
                    // hold until the output register is free, then transfer
                    if (out_load)
                    begin
                        out_data_reg <= result;
                        state_reg    <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/lrt_checker.sv =====
module lrt_checker
    import lrt_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input logic     out_valid,
    input logic     out_stall,
    input lrt_out_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    a_event_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.event_valid == (out_data.status == ST_DONE)))
        else $error("event flag disagrees with status");

    a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.event_valid |->
            out_data.event_port == 16'd0 && out_data.event_address_high == 64'd0 &&
            out_data.event_address_low == 64'd0 && out_data.event_protocol == 8'd0)
        else $error("fields set without event");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transfer taken while busy");

endmodule

bind listener_refcount_tracker_core lrt_checker u_lrt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import lrt_pkg::*;

    localparam int KEYS        = 10;
    localparam int SOCKS       = 24;
    localparam int CYCLE_LIMIT = 40_000_000;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    lrt_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    lrt_out_t out_data;
    logic     cfg_valid;
    logic     cfg_ready;
    logic [31:0] cfg_data;

    listener_refcount_tracker_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the block's tables and namespace register
    bit          port_used  [PORT_ENTRIES];
    lrt_key_t    port_lkey  [PORT_ENTRIES];
    bit [31:0]   port_refs  [PORT_ENTRIES];
    bit          sock_used  [SOCK_ENTRIES];
    bit [63:0]   sock_tag   [SOCK_ENTRIES];
    lrt_key_t    sock_key   [SOCK_ENTRIES];
    int          sock_age   [SOCK_ENTRIES];
    bit [31:0]   host_ns;

    // Stimulus pools: a handful of keys and sockets so that counts climb and fall
    bit [15:0]   pool_fam   [KEYS];
    bit [15:0]   pool_port  [KEYS];
    bit [7:0]    pool_proto [KEYS];
    bit [31:0]   pool_v4    [KEYS];
    bit [63:0]   pool_v6hi  [KEYS];
    bit [63:0]   pool_v6lo  [KEYS];
    bit [63:0]   pool_sock  [SOCKS];

    lrt_in_t     pending_items[$];
    lrt_out_t    expected_results[$];

    int          mismatches;
    int          cycles;
    int          transfers_in;
    int          transfers_out;
    int          status_hits[8];
    int          send_gap = 0;
    int          stall_gap = 0;
    bit          quiet_stretch = 1'b0;

    // Clock and the one reset at the start
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("mismatch on transfer %0d: %s got %h want %h", transfers_out, field,
                 got, want);
    endtask

    // Build the listener key; 0 when the port or the family is not usable
    function automatic bit form_key(input lrt_in_t d, output lrt_key_t k);
        k = '0;
        if (d.local_port == 16'd0)
            return 1'b0;
        k.pp = {d.protocol, d.local_port};
        if (d.address_family == FAM_IPV4)
        begin
            k.hi = 64'd0;
            k.lo = {32'h0000FFFF, d.ipv4_address};
            return 1'b1;
        end
        if (d.address_family == FAM_IPV6)
        begin
            k.hi = d.ipv6_address_high;
            k.lo = d.ipv6_address_low;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Loopback gateway in mapped form, or the FD77 prefix ending in .2
    function automatic bit on_gateway(input lrt_key_t k);
        return (k.lo[47:0] == 48'hFFFF7F000002) ||
               (k.hi[63:48] == 16'hFD77 && k.lo[7:0] == 8'h02);
    endfunction

    function int find_port(input lrt_key_t k);
        for (int i = 0; i < PORT_ENTRIES; i++)
            if (port_used[i] && port_lkey[i] == k)
                return i;
        return -1;
    endfunction

    function int find_socket(input bit [63:0] tag);
        for (int i = 0; i < SOCK_ENTRIES; i++)
            if (sock_used[i] && sock_tag[i] == tag)
                return i;
        return -1;
    endfunction

    // Remember the key for a socket; evict the oldest entry when no slot is free
    function void remember_socket(input bit [63:0] tag, input lrt_key_t k);
        int slot;
        int ceiling;
        bit fresh;
        slot = find_socket(tag);
        fresh = 1'b0;
        ceiling = 32'h7FFFFFFF;
        if (slot < 0)
        begin
            for (int i = 0; i < SOCK_ENTRIES; i++)
                if (!sock_used[i])
                begin
                    slot = i;
                    fresh = 1'b1;
                    break;
                end
        end
        if (slot < 0)
        begin
            slot = 0;
            for (int i = 1; i < SOCK_ENTRIES; i++)
                if (sock_age[i] > sock_age[slot])
                    slot = i;
        end
        if (!fresh)
            ceiling = sock_age[slot];
        for (int i = 0; i < SOCK_ENTRIES; i++)
            if (sock_used[i] && i != slot && sock_age[i] < ceiling)
                sock_age[i]++;
        sock_used[slot] = 1'b1;
        sock_tag[slot]  = tag;
        sock_key[slot]  = k;
        sock_age[slot]  = 0;
    endfunction

    function void forget_socket(input int slot);
        for (int i = 0; i < SOCK_ENTRIES; i++)
            if (sock_used[i] && i != slot && sock_age[i] > sock_age[slot])
                sock_age[i]--;
        sock_used[slot] = 1'b0;
        sock_age[slot]  = 0;
    endfunction

    // Work out the result of one listener event and update the shadow tables
    function lrt_out_t listener_outcome(input lrt_in_t d);
        lrt_out_t r;
        lrt_key_t k;
        int p;
        int s;
        r = '0;
        k = '0;
        if (d.command == CMD_ADD && !d.hook_succeeded)
        begin
            r.status = ST_BAD;
            return r;
        end
        if (host_ns != 32'd0 && d.socket_namespace != host_ns)
        begin
            r.status = ST_FOREIGN;
            return r;
        end
        if (d.command == CMD_ADD)
        begin
            if (!form_key(d, k))
            begin
                r.status = ST_BAD;
                return r;
            end
            if (on_gateway(k))
            begin
                r.status = ST_GATEWAY;
                return r;
            end
            remember_socket(d.socket_id, k);
            p = find_port(k);
            if (p >= 0)
            begin
                if (port_refs[p] != 32'hFFFFFFFF)
                    port_refs[p]++;
                r.status = ST_SILENT;
                return r;
            end
            for (p = 0; p < PORT_ENTRIES; p++)
                if (!port_used[p])
                    break;
            if (p >= PORT_ENTRIES)
            begin
                r.status = ST_FULL;
                return r;
            end
            port_used[p] = 1'b1;
            port_lkey[p] = k;
            port_refs[p] = 32'd1;
            r.event_kind = KIND_APPEAR;
        end
        else
        begin
            s = find_socket(d.socket_id);
            if (s >= 0)
            begin
                k = sock_key[s];
                forget_socket(s);
            end
            else if (!form_key(d, k))
            begin
                r.status = ST_BAD;
                return r;
            end
            if (on_gateway(k))
            begin
                r.status = ST_GATEWAY;
                return r;
            end
            p = find_port(k);
            if (p < 0)
            begin
                r.status = ST_UNTRACKED;
                return r;
            end
            port_refs[p]--;
            if (port_refs[p] != 32'd0)
            begin
                r.status = ST_SILENT;
                return r;
            end
            port_used[p] = 1'b0;
            r.event_kind = KIND_VANISH;
        end
        r.event_valid        = 1'b1;
        r.event_protocol     = k.pp[23:16];
        r.event_port         = k.pp[15:0];
        r.event_address_high = k.hi;
        r.event_address_low  = k.lo;
        r.status             = ST_DONE;
        return r;
    endfunction

    // Mostly short gaps, a few long ones, none during a quiet stretch
    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic lrt_in_t listener_item(input logic cmd, input int s, input int k,
                                              input bit [31:0] ns);
        lrt_in_t d;
        d.command           = cmd;
        d.socket_id         = pool_sock[s];
        d.protocol          = pool_proto[k];
        d.address_family    = pool_fam[k];
        d.local_port        = pool_port[k];
        d.ipv4_address      = pool_v4[k];
        d.ipv6_address_high = pool_v6hi[k];
        d.ipv6_address_low  = pool_v6lo[k];
        d.socket_namespace  = ns;
        d.hook_succeeded    = 1'b1;
        return d;
    endfunction

    function automatic lrt_in_t noise_item();
        lrt_in_t d;
        d.command           = 1'($urandom_range(0, 1));
        d.socket_id         = {$urandom, $urandom};
        d.protocol          = 8'($urandom);
        d.address_family    = 16'($urandom);
        d.local_port        = 16'($urandom);
        d.ipv4_address      = $urandom;
        d.ipv6_address_high = {$urandom, $urandom};
        d.ipv6_address_low  = {$urandom, $urandom};
        d.socket_namespace  = $urandom;
        d.hook_succeeded    = 1'($urandom_range(0, 1));
        // Pull the family toward the usable values now and then
        if ($urandom_range(0, 1))
            d.address_family = $urandom_range(0, 1) ? FAM_IPV4 : FAM_IPV6;
        return d;
    endfunction

    // Driver: hold a stalled transfer, otherwise advance from the pending queue
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(listener_outcome(in_data));
                transfers_in++;
            end
            if (in_valid && in_stall)
            begin
                in_valid <= 1'b1;
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                in_data  <= pending_items.pop_front();
                in_valid <= 1'b1;
                send_gap = pick_gap(quiet_stretch);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        lrt_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            transfers_out++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                $display("unexpected result transfer %0d: %p", transfers_out, out_data);
            end
            else
            begin
                want = expected_results.pop_front();
                status_hits[want.status]++;
                if (out_data.event_valid !== want.event_valid)
                    report_mismatch("event_valid", 64'(out_data.event_valid),
                                    64'(want.event_valid));
                if (out_data.event_kind !== want.event_kind)
                    report_mismatch("event_kind", 64'(out_data.event_kind),
                                    64'(want.event_kind));
                if (out_data.event_protocol !== want.event_protocol)
                    report_mismatch("event_protocol", 64'(out_data.event_protocol),
                                    64'(want.event_protocol));
                if (out_data.event_port !== want.event_port)
                    report_mismatch("event_port", 64'(out_data.event_port),
                                    64'(want.event_port));
                if (out_data.event_address_high !== want.event_address_high)
                    report_mismatch("event_address_high", out_data.event_address_high,
                                    want.event_address_high);
                if (out_data.event_address_low !== want.event_address_low)
                    report_mismatch("event_address_low", out_data.event_address_low,
                                    want.event_address_low);
                if (out_data.status !== want.status)
                    report_mismatch("status", 64'(out_data.status), 64'(want.status));
            end
        end
        // Stall in runs: mostly short, a few long, none during a quiet stretch
        if (stall_gap > 0)
        begin
            stall_gap--;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_gap = pick_gap(quiet_stretch);
            out_stall <= 1'b0;
        end
    end

    // Cycle count, quiet stretches, and the hard limit
    always @(posedge clk)
    begin
        cycles++;
        if ($urandom_range(0, 299) == 0)
            quiet_stretch <= ~quiet_stretch;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_namespace(input bit [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        host_ns = value;
    endtask

    // Drain: wait until every queued item went in and every result came back
    task automatic drain();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic queue_random(input int count);
        int k;
        int s;
        bit [31:0] ns;
        lrt_in_t d;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 20)
            begin
                d = noise_item();
                if ($urandom_range(0, 1))
                    d.socket_namespace = host_ns;
            end
            else
            begin
                k = $urandom_range(0, KEYS - 1);
                s = $urandom_range(0, SOCKS - 1);
                ns = ($urandom_range(0, 9) == 0) ? $urandom : host_ns;
                d = listener_item($urandom_range(0, 99) < 55 ? CMD_ADD : CMD_REMOVE, s, k, ns);
                if ($urandom_range(0, 19) == 0)
                    d.hook_succeeded = 1'b0;
            end
            pending_items.push_back(d);
        end
    endtask

    initial
    begin
        lrt_in_t d;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        host_ns   = '0;
        for (int i = 0; i < KEYS; i++)
        begin
            pool_fam[i]   = (i % 2) ? FAM_IPV6 : FAM_IPV4;
            pool_port[i]  = 16'($urandom_range(1, 65535));
            pool_proto[i] = $urandom_range(0, 1) ? 8'd6 : 8'd17;
            pool_v4[i]    = $urandom;
            pool_v6hi[i]  = {$urandom, $urandom};
            pool_v6lo[i]  = {$urandom, $urandom};
        end
        // Two of the keys land on gateway addresses
        pool_v4[KEYS - 2]   = 32'h7F000002;
        pool_v6hi[KEYS - 1] = {16'hFD77, 48'h0};
        pool_v6lo[KEYS - 1][7:0] = 8'h02;
        for (int i = 0; i < SOCKS; i++)
            pool_sock[i] = {$urandom, $urandom};
        pool_sock[0] = 64'd0;
        pool_sock[1] = '1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: filters, bad keys, gateways, count up and down
        write_namespace(32'd0);
        d = listener_item(CMD_ADD, 2, 0, 32'd0);
        d.hook_succeeded = 1'b0;
        pending_items.push_back(d);
        d = listener_item(CMD_ADD, 2, 0, 32'd0);
        d.local_port = 16'd0;
        pending_items.push_back(d);
        d = listener_item(CMD_ADD, 2, 0, 32'd0);
        d.address_family = 16'd7;
        pending_items.push_back(d);
        pending_items.push_back(listener_item(CMD_ADD, 2, KEYS - 2, 32'd0));
        pending_items.push_back(listener_item(CMD_ADD, 2, KEYS - 1, 32'd0));
        pending_items.push_back(listener_item(CMD_ADD, 0, 0, 32'd0));
        pending_items.push_back(listener_item(CMD_ADD, 0, 0, 32'd0));
        pending_items.push_back(listener_item(CMD_ADD, 1, 0, 32'd0));
        pending_items.push_back(listener_item(CMD_REMOVE, 0, 0, 32'd0));
        pending_items.push_back(listener_item(CMD_REMOVE, 1, 0, 32'd0));
        pending_items.push_back(listener_item(CMD_REMOVE, 3, 1, 32'd0));
        d = listener_item(CMD_REMOVE, 3, 1, 32'd0);
        d.address_family = '1;
        pending_items.push_back(d);
        pending_items.push_back(listener_item(CMD_REMOVE, 3, KEYS - 2, 32'd0));
        d = '1;
        d.command = CMD_ADD;
        d.address_family = FAM_IPV6;
        pending_items.push_back(d);
        d.command = CMD_REMOVE;
        d.hook_succeeded = 1'b0;
        pending_items.push_back(d);
        d = '0;
        d.hook_succeeded = 1'b1;
        d.address_family = FAM_IPV4;
        d.local_port = 16'd1;
        pending_items.push_back(d);
        // Re-add under another key: the remove must use the new key
        pending_items.push_back(listener_item(CMD_ADD, 4, 2, 32'd0));
        pending_items.push_back(listener_item(CMD_ADD, 4, 3, 32'd0));
        pending_items.push_back(listener_item(CMD_REMOVE, 4, 2, 32'd0));
        drain();

        write_namespace('1);
        pending_items.push_back(listener_item(CMD_ADD, 5, 4, 32'd1));
        pending_items.push_back(listener_item(CMD_ADD, 5, 4, '1));
        pending_items.push_back(listener_item(CMD_REMOVE, 5, 4, 32'd0));
        pending_items.push_back(listener_item(CMD_REMOVE, 5, 4, '1));
        queue_random(230);
        drain();

        write_namespace($urandom_range(2, 32'hFFFFFFFE));
        queue_random(230);
        drain();

        write_namespace(32'd0);
        queue_random(240);
        drain();

        $display("%0d items in, %0d results out over %0d cycles", transfers_in,
                 transfers_out, cycles);
        $display("outcomes: done %0d foreign %0d bad %0d gateway %0d untracked %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4]);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
